// ===== rtl/mcfp_pkg.sv =====
// shared types and constants of the motor command frame packer
// no dependencies
`timescale 1ns / 1ps

package mcfp_pkg;

	localparam int ID_W     = 11;
	localparam int VAL_W    = 32;
	localparam int LIM_W    = 31;
	localparam int CODE_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int DIV_STAGES = 16;
	localparam int PIPE_DEPTH = DIV_STAGES + 2;

	localparam logic [CFG_IDX_W-1:0] REG_POSITION  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VELOCITY  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TORQUE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 3'd4;

	localparam logic [LIM_W-1:0] POSITION_RESET  = 31'd819200;
	localparam logic [LIM_W-1:0] VELOCITY_RESET  = 31'd2949120;
	localparam logic [LIM_W-1:0] TORQUE_RESET    = 31'd1572864;
	localparam logic [LIM_W-1:0] STIFFNESS_RESET = 31'd32768000;
	localparam logic [LIM_W-1:0] DAMPING_RESET   = 31'd327680;

	typedef struct packed {
		logic [LIM_W-1:0] position;
		logic [LIM_W-1:0] velocity;
		logic [LIM_W-1:0] torque;
		logic [LIM_W-1:0] stiffness;
		logic [LIM_W-1:0] damping;
	} limits_t;

	typedef struct packed {
		logic              hi;
		logic              lo;
		logic              wide;
		logic [VAL_W-1:0]  den;
		logic [VAL_W-1:0]  r;
		logic [CODE_W-1:0] low;
		logic [CODE_W-1:0] q;
	} div_stage_t;

endpackage

// ===== rtl/mcfp_cmd_if.sv =====
// command, frame and configuration channels
// depends on mcfp_pkg
`timescale 1ns / 1ps

interface mcfp_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [mcfp_pkg::ID_W-1:0]         frame_id;
	logic signed [mcfp_pkg::VAL_W-1:0] target_position;
	logic signed [mcfp_pkg::VAL_W-1:0] target_velocity;
	logic signed [mcfp_pkg::VAL_W-1:0] stiffness_gain;
	logic signed [mcfp_pkg::VAL_W-1:0] damping_gain;
	logic signed [mcfp_pkg::VAL_W-1:0] feedforward_torque;

	modport source (output valid, frame_id, target_position, target_velocity,
		stiffness_gain, damping_gain, feedforward_torque, input ready);
	modport sink (input valid, frame_id, target_position, target_velocity,
		stiffness_gain, damping_gain, feedforward_torque, output ready);
endinterface

interface mcfp_frame_if;
	logic                        valid;
	logic                        ready;
	logic [mcfp_pkg::ID_W-1:0]   out_frame_id;
	logic [mcfp_pkg::VAL_W-1:0]  payload_low;
	logic [mcfp_pkg::VAL_W-1:0]  payload_high;

	modport source (output valid, out_frame_id, payload_low, payload_high, input ready);
	modport sink (input valid, out_frame_id, payload_low, payload_high, output ready);
endinterface

interface mcfp_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [mcfp_pkg::CFG_IDX_W-1:0]  index;
	logic [mcfp_pkg::LIM_W-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/mcfp_cfg_regs.sv =====
// limit registers written over the configuration channel
// depends on mcfp_pkg and mcfp_cfg_if
`timescale 1ns / 1ps

module mcfp_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	mcfp_cfg_if.sink          cfg,
	output mcfp_pkg::limits_t limits
);
	import mcfp_pkg::*;

	limits_t lim_q;

	assign cfg.ready = 1'b1;
	assign limits    = lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q.position  <= POSITION_RESET;
			lim_q.velocity  <= VELOCITY_RESET;
			lim_q.torque    <= TORQUE_RESET;
			lim_q.stiffness <= STIFFNESS_RESET;
			lim_q.damping   <= DAMPING_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_POSITION:  lim_q.position  <= cfg.data;
				REG_VELOCITY:  lim_q.velocity  <= cfg.data;
				REG_TORQUE:    lim_q.torque    <= cfg.data;
				REG_STIFFNESS: lim_q.stiffness <= cfg.data;
				REG_DAMPING:   lim_q.damping   <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/mcfp_quant_lane.sv =====
// one quantizer lane: range check, scaling, then a 16-stage restoring divider
// depends on mcfp_pkg
`timescale 1ns / 1ps

module mcfp_quant_lane (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [mcfp_pkg::VAL_W-1:0] x,
	input  logic [mcfp_pkg::LIM_W-1:0]        limit,
	input  logic                              sym,
	input  logic                              wide,
	output logic [mcfp_pkg::CODE_W-1:0]       code
);
	import mcfp_pkg::*;

	logic signed [VAL_W:0] x_e, hi_e, lo_e, num_e;
	logic [VAL_W-1:0]      den_c;

	logic              hi_s1, lo_s1, wide_s1;
	logic [VAL_W-1:0]  num_s1, den_s1;

	logic [VAL_W+CODE_W-1:0] sub_c, nprime_c;
	div_stage_t              first_c;
	div_stage_t              div_s [0:DIV_STAGES];

	always_comb begin
		x_e   = {x[VAL_W-1], x};
		hi_e  = {2'b00, limit};
		lo_e  = sym ? -hi_e : '0;
		num_e = x_e - lo_e;
		den_c = sym ? {limit, 1'b0} : {1'b0, limit};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hi_s1   <= x_e >= hi_e;
			lo_s1   <= x_e <= lo_e;
			wide_s1 <= wide;
			num_s1  <= num_e[VAL_W-1:0];
			den_s1  <= den_c;
		end
	end

	// numerator times (2^bits - 1), scaled to 16 quotient bits
	always_comb begin
		sub_c = wide_s1 ? {16'b0, num_s1} : {12'b0, num_s1, 4'b0};
		nprime_c = {num_s1, 16'b0} - sub_c;
		first_c.hi   = hi_s1;
		first_c.lo   = lo_s1;
		first_c.wide = wide_s1;
		first_c.den  = den_s1;
		first_c.r    = nprime_c[VAL_W+CODE_W-1:CODE_W];
		first_c.low  = nprime_c[CODE_W-1:0];
		first_c.q    = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0] <= first_c;
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		logic [VAL_W:0] t_c, diff_c;
		logic           take_c;
		div_stage_t     nxt_c;

		always_comb begin
			t_c    = {div_s[k].r, div_s[k].low[CODE_W-1]};
			diff_c = t_c - {1'b0, div_s[k].den};
			take_c = t_c >= {1'b0, div_s[k].den};
			nxt_c     = div_s[k];
			nxt_c.r   = take_c ? diff_c[VAL_W-1:0] : t_c[VAL_W-1:0];
			nxt_c.low = {div_s[k].low[CODE_W-2:0], 1'b0};
			nxt_c.q   = {div_s[k].q[CODE_W-2:0], take_c};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k+1] <= nxt_c;
			end
		end
	end

	always_comb begin
		if (div_s[DIV_STAGES].hi) begin
			code = div_s[DIV_STAGES].wide ? 16'hFFFF : 16'h0FFF;
		end else if (div_s[DIV_STAGES].lo) begin
			code = '0;
		end else if (div_s[DIV_STAGES].wide) begin
			code = div_s[DIV_STAGES].q;
		end else begin
			code = {4'b0, div_s[DIV_STAGES].q[CODE_W-1:4]};
		end
	end

endmodule

// ===== rtl/motor_command_frame_pack_core.sv =====
// path: check register, scaling register, divider stages, then the output register
// throughput: one item per cycle unless the output stalls; each of the five lanes runs a 16-stage divider
// the whole pipeline advances together and holds while the output register waits
// reset: valid bits cleared and limit registers return to their defaults, data not reset
// depends on mcfp_pkg, the channel interfaces, mcfp_cfg_regs and mcfp_quant_lane
`timescale 1ns / 1ps

module motor_command_frame_pack_core (
	input  logic clk,
	input  logic arst_n,
	mcfp_cmd_if.sink     cmd,
	mcfp_frame_if.source frm,
	mcfp_cfg_if.sink     cfg
);
	import mcfp_pkg::*;

	limits_t             limits;
	logic                adv;
	logic [PIPE_DEPTH-1:0] v_s;
	logic [ID_W-1:0]     id_s [0:PIPE_DEPTH-1];
	logic [CODE_W-1:0]   pos_c, vel_c, kp_c, kd_c, tq_c;

	logic                out_valid_q;
	logic [ID_W-1:0]     out_id_q;
	logic [VAL_W-1:0]    out_low_q, out_high_q;

	mcfp_cfg_regs u_cfg (.clk(clk), .arst_n(arst_n), .cfg(cfg), .limits(limits));

	assign adv       = !out_valid_q || frm.ready;
	assign cmd.ready = adv;

	mcfp_quant_lane u_pos (.clk(clk), .en(adv), .x(cmd.target_position),
		.limit(limits.position), .sym(1'b1), .wide(1'b1), .code(pos_c));
	mcfp_quant_lane u_vel (.clk(clk), .en(adv), .x(cmd.target_velocity),
		.limit(limits.velocity), .sym(1'b1), .wide(1'b0), .code(vel_c));
	mcfp_quant_lane u_kp (.clk(clk), .en(adv), .x(cmd.stiffness_gain),
		.limit(limits.stiffness), .sym(1'b0), .wide(1'b0), .code(kp_c));
	mcfp_quant_lane u_kd (.clk(clk), .en(adv), .x(cmd.damping_gain),
		.limit(limits.damping), .sym(1'b0), .wide(1'b0), .code(kd_c));
	mcfp_quant_lane u_tq (.clk(clk), .en(adv), .x(cmd.feedforward_torque),
		.limit(limits.torque), .sym(1'b1), .wide(1'b0), .code(tq_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s         <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s         <= {v_s[PIPE_DEPTH-2:0], cmd.valid};
			out_valid_q <= v_s[PIPE_DEPTH-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			id_s[0] <= cmd.frame_id;
			for (int i = 1; i < PIPE_DEPTH; i++) begin
				id_s[i] <= id_s[i-1];
			end
			out_id_q   <= id_s[PIPE_DEPTH-1];
			out_low_q  <= {vel_c[3:0], kp_c[11:8], vel_c[11:4], pos_c[7:0], pos_c[15:8]};
			out_high_q <= {tq_c[7:0], kd_c[3:0], tq_c[11:8], kd_c[11:4], kp_c[7:0]};
		end
	end

	assign frm.valid        = out_valid_q;
	assign frm.out_frame_id = out_id_q;
	assign frm.payload_low  = out_low_q;
	assign frm.payload_high = out_high_q;

	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready == (!frm.valid || frm.ready))
		else $error("command ready does not follow output stall");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> v_s[0])
		else $error("accepted command missing from first stage");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s))
		else $error("pipeline moved during a stall");

endmodule

// ===== sim/motor_command_frame_pack_core_test.sv =====
// testbench of motor_command_frame_pack_core: directed table, then random commands
// over several limit settings, each frame checked against table values or an in-bench quantizer
// depends on mcfp_pkg, the channel interfaces and motor_command_frame_pack_core
`timescale 1ns / 1ps

module motor_command_frame_pack_core_test;
	import mcfp_pkg::*;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [VAL_W-1:0] low;
		logic [VAL_W-1:0] high;
	} frame_t;

	typedef struct {
		logic [ID_W-1:0]  id;
		logic [VAL_W-1:0] pos;
		logic [VAL_W-1:0] vel;
		logic [VAL_W-1:0] kp;
		logic [VAL_W-1:0] kd;
		logic [VAL_W-1:0] tq;
		bit               typed;
		logic [VAL_W-1:0] low;
		logic [VAL_W-1:0] high;
	} cmd_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mcfp_cmd_if   cmd ();
	mcfp_frame_if frm ();
	mcfp_cfg_if   cfg ();

	motor_command_frame_pack_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd.sink),
		.frm    (frm.source),
		.cfg    (cfg.sink)
	);

	always #5 clk = ~clk;

	limits_t  lim;
	frame_t   frames_due[$];
	int       mismatches = 0;
	bit       row_typed = 1'b0;
	frame_t   row_frame;
	int       hold_asked = 0;
	int       hold_seen = 0;
	int       stall_left = 0;
	int       quiet_left = 0;

	function automatic logic [15:0] quantize(longint x, longint lo, longint hi, int bits);
		longint full;
		longint num;
		longint den;
		full = (longint'(1) << bits) - 1;
		if (x >= hi)
			return full[15:0];
		if (x <= lo)
			return 16'd0;
		num = x - lo;
		den = hi - lo;
		return 16'((num * full) / den);
	endfunction

	function automatic frame_t pack_frame(logic [ID_W-1:0] id, logic [VAL_W-1:0] p,
		logic [VAL_W-1:0] v, logic [VAL_W-1:0] k, logic [VAL_W-1:0] d,
		logic [VAL_W-1:0] t);
		frame_t f;
		logic [15:0] qp, qv, qk, qd, qt;
		longint pl, vl, tl;
		pl = longint'(lim.position);
		vl = longint'(lim.velocity);
		tl = longint'(lim.torque);
		qp = quantize(longint'($signed(p)), -pl, pl, 16);
		qv = quantize(longint'($signed(v)), -vl, vl, 12);
		qk = quantize(longint'($signed(k)), 0, longint'(lim.stiffness), 12);
		qd = quantize(longint'($signed(d)), 0, longint'(lim.damping), 12);
		qt = quantize(longint'($signed(t)), -tl, tl, 12);
		f.id = id;
		f.low = {qv[3:0], qk[11:8], qv[11:4], qp[7:0], qp[15:8]};
		f.high = {qt[7:0], qd[3:0], qt[11:8], qd[11:4], qk[7:0]};
		return f;
	endfunction

	task automatic report(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// expected frames recorded at command acceptance
	always @(posedge clk) begin
		if (arst_n && cmd.valid && cmd.ready) begin
			if (row_typed)
				frames_due.push_back(row_frame);
			else
				frames_due.push_back(pack_frame(cmd.frame_id, cmd.target_position,
					cmd.target_velocity, cmd.stiffness_gain, cmd.damping_gain,
					cmd.feedforward_torque));
		end
	end

	// frame checker
	always @(posedge clk) begin
		frame_t w;
		if (arst_n && frm.valid && frm.ready) begin
			if (frames_due.size() == 0) begin
				report("unexpected frame", frm.payload_low, '0);
			end else begin
				w = frames_due.pop_front();
				if (frm.out_frame_id !== w.id)
					report("out_frame_id", VAL_W'(frm.out_frame_id), VAL_W'(w.id));
				if (frm.payload_low !== w.low)
					report("payload_low", frm.payload_low, w.low);
				if (frm.payload_high !== w.high)
					report("payload_high", frm.payload_high, w.high);
			end
		end
	end

	// frame receiver backpressure
	initial frm.ready = 1'b0;
	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 999);
		if (hold_asked != hold_seen) begin
			hold_seen = hold_asked;
			stall_left = 300;
		end
		if (stall_left > 0) begin
			frm.ready <= 1'b0;
			stall_left--;
		end else if (quiet_left > 0) begin
			frm.ready <= 1'b1;
			quiet_left--;
		end else if (r < 5) begin
			quiet_left = $urandom_range(50, 200);
			frm.ready <= 1'b1;
		end else if (r < 15) begin
			stall_left = $urandom_range(10, 50);
			frm.ready <= 1'b0;
		end else begin
			frm.ready <= (r < 700);
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	bit no_gaps = 1'b0;

	task automatic send_cmd(cmd_row_t c);
		int n;
		cmd.valid <= 1'b1;
		cmd.frame_id <= c.id;
		cmd.target_position <= c.pos;
		cmd.target_velocity <= c.vel;
		cmd.stiffness_gain <= c.kp;
		cmd.damping_gain <= c.kd;
		cmd.feedforward_torque <= c.tq;
		row_typed <= c.typed;
		row_frame <= '{c.id, c.low, c.high};
		do @(posedge clk); while (!cmd.ready);
		n = no_gaps ? 0 : gap_len();
		if (n > 0) begin
			cmd.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [LIM_W-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			REG_POSITION:  lim.position = val;
			REG_VELOCITY:  lim.velocity = val;
			REG_TORQUE:    lim.torque = val;
			REG_STIFFNESS: lim.stiffness = val;
			REG_DAMPING:   lim.damping = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 6) @(posedge clk);
	endtask

	function automatic logic [VAL_W-1:0] pick_val(logic [LIM_W-1:0] l, bit sym);
		longint lo, span, x;
		lo = sym ? -longint'(l) : 0;
		span = longint'(l) - lo + 1;
		case ($urandom_range(0, 9))
			0: x = longint'($signed($urandom()));
			1: x = longint'(l) + $signed($urandom_range(0, 6)) - 3;
			2: x = lo + $signed($urandom_range(0, 6)) - 3;
			3: x = $urandom_range(0, 1) ? 32'sh7fffffff : -32'sh80000000;
			4: x = $signed($urandom_range(0, 8)) - 4;
			default: x = lo + longint'({$urandom(), $urandom()} % span);
		endcase
		return x[VAL_W-1:0];
	endfunction

	task automatic random_cmds(int count);
		cmd_row_t c;
		for (int i = 0; i < count; i++) begin
			c.id = ID_W'($urandom());
			c.pos = pick_val(lim.position, 1'b1);
			c.vel = pick_val(lim.velocity, 1'b1);
			c.kp = pick_val(lim.stiffness, 1'b0);
			c.kd = pick_val(lim.damping, 1'b0);
			c.tq = pick_val(lim.torque, 1'b1);
			c.typed = 1'b0;
			c.low = '0;
			c.high = '0;
			send_cmd(c);
		end
	endtask

	task automatic set_all(logic [LIM_W-1:0] p, logic [LIM_W-1:0] v, logic [LIM_W-1:0] t,
		logic [LIM_W-1:0] k, logic [LIM_W-1:0] d);
		write_limit(REG_POSITION, p);
		write_limit(REG_VELOCITY, v);
		write_limit(REG_TORQUE, t);
		write_limit(REG_STIFFNESS, k);
		write_limit(REG_DAMPING, d);
	endtask

	cmd_row_t rows[] = '{
		'{11'h000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1, 32'hF07FFF7F, 32'hFF070000},
		'{11'h7FF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			1, 32'hFFFFFFFF, 32'hFFFFFFFF},
		'{11'h000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			1, 32'h0, 32'h0},
		'{11'h555, 32'd819200, 32'd2949120, 32'd32768000, 32'd327680, 32'd1572864,
			1, 32'hFFFFFFFF, 32'hFFFFFFFF},
		'{11'h2AA, -32'sd819200, -32'sd2949120, -32'sd32768000, -32'sd327680,
			-32'sd1572864, 1, 32'h0, 32'h0},
		'{11'h001, 32'd819199, 32'd2949119, 32'd32767999, 32'd327679, 32'd1572863,
			0, 0, 0},
		'{11'h400, -32'sd819199, -32'sd2949119, 32'd1, 32'd1, -32'sd1572863, 0, 0, 0},
		'{11'h123, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			0, 0, 0},
		'{11'h3C5, 32'd1, 32'd1, 32'd16384000, 32'd163840, 32'd1, 0, 0, 0},
		'{11'h6AB, 32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h12345678,
			0, 0, 0},
		'{11'h0F0, 32'd409600, -32'sd1474560, 32'd65536, 32'd65536, 32'd786432, 0, 0, 0}
	};

	initial begin
		cmd.valid = 1'b0;
		cmd.frame_id = '0;
		cmd.target_position = '0;
		cmd.target_velocity = '0;
		cmd.stiffness_gain = '0;
		cmd.damping_gain = '0;
		cmd.feedforward_torque = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		lim = '{POSITION_RESET, VELOCITY_RESET, TORQUE_RESET, STIFFNESS_RESET, DAMPING_RESET};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			send_cmd(rows[i]);
		random_cmds(60);
		// long receiver hold while commands keep coming
		hold_asked++;
		no_gaps = 1'b1;
		random_cmds(40);
		no_gaps = 1'b0;
		drain();

		set_all(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
		// writes to unused indexes are ignored
		for (int k = int'(REG_DAMPING) + 1; k < (1 << CFG_IDX_W); k++)
			write_limit(CFG_IDX_W'(k), LIM_W'($urandom()));
		random_cmds(60);
		drain();

		set_all(31'd1, 31'd1, 31'd1, 31'd1, 31'd1);
		random_cmds(50);
		drain();

		// collapsed ranges
		set_all(31'd0, 31'd0, 31'd0, 31'd0, 31'd0);
		random_cmds(50);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			set_all(LIM_W'($urandom()), LIM_W'($urandom_range(1, 1 << 20)),
				LIM_W'($urandom()), LIM_W'($urandom_range(1, 1 << 26)),
				LIM_W'($urandom()));
			random_cmds(50);
			drain();
		end

		set_all(POSITION_RESET, VELOCITY_RESET, TORQUE_RESET, STIFFNESS_RESET,
			DAMPING_RESET);
		random_cmds(20);
		drain();

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/mcfp_pkg.sv
rtl/mcfp_cmd_if.sv
rtl/mcfp_cfg_regs.sv
rtl/mcfp_quant_lane.sv
rtl/motor_command_frame_pack_core.sv
sim/motor_command_frame_pack_core_test.sv
